// File: hdl/crlcm_pkg.sv
package crlcm_pkg;

  localparam int SIZE_BITS = 16;
  localparam int ACC_W     = 31;
  localparam int MAG_W     = SIZE_BITS - 1;
  localparam int PROD_W    = ACC_W + MAG_W;
  localparam int CMP_W     = (ACC_W > MAG_W + 1) ? ACC_W : MAG_W + 1;
  localparam int K_W       = $clog2(MAG_W + 1);
  localparam int CNT_W     = $clog2(MAG_W + 1);
  localparam int PC_W      = 4;

  localparam int IN_TDATA_W  = ((SIZE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ACC_W + 7) / 8) * 8;

  localparam logic [ACC_W-1:0] CAP_RESET = ACC_W'(1 << 20);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_HALVE_AB,
    OP_HALVE_A,
    OP_HALVE_B,
    OP_SWAP,
    OP_SUB,
    OP_SCALE_G,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL,
    OP_COMMIT
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_AB_ODD,
    C_A_ODD,
    C_B_ODD,
    C_A_LE_B,
    C_A_NE_B,
    C_CNT_MORE
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ucode_t;

  // binary gcd of acc and size, then size / gcd, then acc * quotient against cap
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_W'(0):  w = '{op: OP_LOAD,     cond: C_NEVER,    target: PC_W'(0),  last: 1'b0};
      PC_W'(1):  w = '{op: OP_NOP,      cond: C_AB_ODD,   target: PC_W'(3),  last: 1'b0};
      PC_W'(2):  w = '{op: OP_HALVE_AB, cond: C_ALWAYS,   target: PC_W'(1),  last: 1'b0};
      PC_W'(3):  w = '{op: OP_NOP,      cond: C_A_ODD,    target: PC_W'(5),  last: 1'b0};
      PC_W'(4):  w = '{op: OP_HALVE_A,  cond: C_ALWAYS,   target: PC_W'(3),  last: 1'b0};
      PC_W'(5):  w = '{op: OP_NOP,      cond: C_B_ODD,    target: PC_W'(7),  last: 1'b0};
      PC_W'(6):  w = '{op: OP_HALVE_B,  cond: C_ALWAYS,   target: PC_W'(5),  last: 1'b0};
      PC_W'(7):  w = '{op: OP_NOP,      cond: C_A_LE_B,   target: PC_W'(9),  last: 1'b0};
      PC_W'(8):  w = '{op: OP_SWAP,     cond: C_NEVER,    target: PC_W'(0),  last: 1'b0};
      PC_W'(9):  w = '{op: OP_SUB,      cond: C_A_NE_B,   target: PC_W'(5),  last: 1'b0};
      PC_W'(10): w = '{op: OP_SCALE_G,  cond: C_NEVER,    target: PC_W'(0),  last: 1'b0};
      PC_W'(11): w = '{op: OP_DIV_INIT, cond: C_NEVER,    target: PC_W'(0),  last: 1'b0};
      PC_W'(12): w = '{op: OP_DIV_STEP, cond: C_CNT_MORE, target: PC_W'(12), last: 1'b0};
      PC_W'(13): w = '{op: OP_MUL,      cond: C_NEVER,    target: PC_W'(0),  last: 1'b0};
      PC_W'(14): w = '{op: OP_COMMIT,   cond: C_NEVER,    target: PC_W'(0),  last: 1'b1};
      default:   w = '{op: OP_NOP,      cond: C_NEVER,    target: PC_W'(0),  last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/capped_running_lcm.sv
// channel   | tdata                     | tuser      | direction
// ----------+---------------------------+------------+----------
// in_       | size [15:0] signed        | start_req  | slave
// out_      | multiple [30:0], pad [31] | clamped    | master
// cfg_      | cap [30:0] on cfg_wr_data | -          | write only
//
// an item that is skipped or that seeds the multiple goes to S_DONE when it is accepted
// and from there to the output register once that is free; an lcm update runs the
// microcode program: the binary gcd loop (one shift or subtract a step), one restoring
// divide step per magnitude bit and one 31x15 multiply, then a commit against the cap.
// one item is in work at a time; the next is taken while a result waits in the output
// register. synchronous active-low reset, cap resets to 1 << 20.
module capped_running_lcm
  import crlcm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [ACC_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] size
  input  logic                   in_tuser,   // [0] start_req
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [30:0] multiple, [31] zero
  output logic                   out_tuser   // [0] clamped
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              clamp_r, clamp_nxt;
  logic [ACC_W-1:0]  cap_r, cap_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]  out_mult_r, out_mult_nxt;
  logic              out_clamp_r, out_clamp_nxt;

  logic [ACC_W-1:0]  a_r, a_nxt;
  logic [ACC_W-1:0]  b_r, b_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [MAG_W-1:0]  s_r, s_nxt;
  logic [MAG_W-1:0]  rem_r, rem_nxt;
  logic [MAG_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  ucode_t            uw;
  logic              jump;
  logic [SIZE_BITS-1:0] size_in;
  logic              size_pos;
  logic [ACC_W-1:0]  acc_base;
  logic [MAG_W:0]    trial;
  logic [CMP_W-1:0]  diff;
  logic              fits;

  assign uw       = ucode_rom(pc_r);
  assign size_in  = in_tdata[SIZE_BITS-1:0];
  assign size_pos = (size_in != '0) && !size_in[SIZE_BITS-1];
  assign acc_base = in_tuser ? '0 : acc_r;
  assign trial    = {rem_r, quo_r[MAG_W-1]};
  assign diff     = CMP_W'(trial) - CMP_W'(a_r);
  assign fits     = CMP_W'(trial) >= CMP_W'(a_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_mult_r);
  assign out_tuser  = out_clamp_r;

  always_comb begin
    case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_AB_ODD:   jump = a_r[0] | b_r[0];
      C_A_ODD:    jump = a_r[0];
      C_B_ODD:    jump = b_r[0];
      C_A_LE_B:   jump = (a_r <= b_r);
      C_A_NE_B:   jump = (a_r != b_r);
      C_CNT_MORE: jump = (cnt_r != CNT_W'(1));
      default:    jump = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    acc_nxt       = acc_r;
    clamp_nxt     = clamp_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r;
    out_mult_nxt  = out_mult_r;
    out_clamp_nxt = out_clamp_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;

    if (cfg_wr_en) begin
      cap_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          acc_nxt   = acc_base;
          clamp_nxt = in_tuser ? 1'b0 : clamp_r;
          s_nxt     = size_in[MAG_W-1:0];
          state_nxt = S_DONE;
          if (size_pos) begin
            if (acc_base == '0) begin
              acc_nxt = ACC_W'(size_in[MAG_W-1:0]);
            end else begin
              pc_nxt    = '0;
              state_nxt = S_RUN;
            end
          end
        end
      end
      S_RUN: begin
        case (uw.op)
          OP_NOP: ;
          OP_LOAD: begin
            a_nxt = acc_r;
            b_nxt = ACC_W'(s_r);
            k_nxt = '0;
          end
          OP_HALVE_AB: begin
            a_nxt = a_r >> 1;
            b_nxt = b_r >> 1;
            k_nxt = k_r + K_W'(1);
          end
          OP_HALVE_A: a_nxt = a_r >> 1;
          OP_HALVE_B: b_nxt = b_r >> 1;
          OP_SWAP: begin
            a_nxt = b_r;
            b_nxt = a_r;
          end
          OP_SUB:     b_nxt = b_r - a_r;
          OP_SCALE_G: a_nxt = a_r << k_r;
          OP_DIV_INIT: begin
            rem_nxt = '0;
            quo_nxt = s_r;
            cnt_nxt = CNT_W'(MAG_W);
          end
          OP_DIV_STEP: begin
            // remainder stays below the gcd, so it fits the size width
            rem_nxt = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            quo_nxt = {quo_r[MAG_W-2:0], fits};
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          OP_MUL: prod_nxt = {{MAG_W{1'b0}}, acc_r} * {{ACC_W{1'b0}}, quo_r};
          OP_COMMIT: begin
            if (prod_r > PROD_W'(cap_r)) begin
              clamp_nxt = 1'b1;
            end else begin
              acc_nxt = prod_r[ACC_W-1:0];
            end
          end
          default: ;
        endcase
        pc_nxt = jump ? uw.target : pc_r + PC_W'(1);
        if (uw.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_mult_nxt  = acc_r;
          out_clamp_nxt = clamp_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      acc_r       <= '0;
      clamp_r     <= 1'b0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      acc_r       <= acc_nxt;
      clamp_r     <= clamp_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mult_r  <= out_mult_nxt;
    out_clamp_r <= out_clamp_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    k_r         <= k_nxt;
    s_r         <= s_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    prod_r      <= prod_nxt;
  end

endmodule

// File: hdl/crlcm_checker.sv
module crlcm_checker
  import crlcm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // a clamp can only follow a nonzero multiple in the same list
  a_clamp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[ACC_W-1:0] != '0)
    else $error("clamped with zero multiple");

endmodule

bind capped_running_lcm crlcm_checker u_crlcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
